[rtl/core/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, result codes and pipeline payload types of the
// point to line / segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

   // number of coordinate lanes built
   localparam int DIMENSIONS = 3;

   localparam int CRD_W   = 32;              // input coordinate
   localparam int DIFF_W  = CRD_W + 1;       // coordinate difference
   localparam int PROD_W  = 2 * DIFF_W;      // one lane product
   localparam int SUM_W   = PROD_W + 3;      // signed sum over lanes
   localparam int SQ_W    = SUM_W - 1;       // squared lengths, dot magnitude
   localparam int HALF_W  = SQ_W / 2;        // limb of the dot magnitude
   localparam int NUM_W   = 2 * SQ_W;        // dot squared
   localparam int ROOT_W  = SQ_W / 2;        // integer root of a squared length
   localparam int SQR_W   = ROOT_W + 1;      // root remainder
   localparam int DIST_W  = 35;              // result distance

   localparam int DIV_STEPS  = SQ_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int LANE_STAGES  = 2;
   localparam int MERGE_STAGES = 4;
   localparam int LATENCY = LANE_STAGES + MERGE_STAGES + DIV_STEPS + 1 + SQRT_STEPS + 1;

   localparam logic [1:0] DIMS_RESET = 2'd3;

   // nearest_case codes
   localparam logic [1:0] CASE_PERP  = 2'd0;
   localparam logic [1:0] CASE_START = 2'd1;
   localparam logic [1:0] CASE_END   = 2'd2;
   localparam logic [1:0] CASE_DEGEN = 2'd3;

   typedef struct packed {
      logic degenerate;
      logic seg_end;
   } psd_ctrl_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] ab_ab;
      logic signed [PROD_W-1:0] ap_ap;
      logic signed [PROD_W-1:0] bp_bp;
      logic signed [PROD_W-1:0] ab_ap;
      logic signed [PROD_W-1:0] ab_bp;
   } psd_prod_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] quo;
      logic [SQ_W-1:0] dvs;
      logic [SQ_W-1:0] ap2;
      logic [SQ_W-1:0] bp2;
      psd_ctrl_type    ctrl;
   } psd_div_type;

   typedef struct packed {
      logic [SQ_W-1:0]   rad;
      logic [SQR_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } psd_sqrt_type;

endpackage

[rtl/core/psd_lane.sv]
// ----------------------------------------------------------------------------
// psd_lane
// One coordinate lane: differences, then the five lane products.
// ----------------------------------------------------------------------------
module psd_lane (
   input  logic                          clock,
   input  logic                          adv,
   input  logic                          active,
   input  logic signed [psd_pkg::CRD_W-1:0] crd_a,
   input  logic signed [psd_pkg::CRD_W-1:0] crd_b,
   input  logic signed [psd_pkg::CRD_W-1:0] crd_p,
   output psd_pkg::psd_prod_type         prod
);
   import psd_pkg::*;

   logic signed [DIFF_W-1:0] ab_ff, ap_ff, bp_ff;
   logic signed [DIFF_W-1:0] ab_in, ap_in, bp_in;
   psd_prod_type             prod_ff, prod_in;

   // differences, unused coordinates read as zero
   always_comb begin
      if (active) begin
         ab_in = DIFF_W'(crd_b) - DIFF_W'(crd_a);
         ap_in = DIFF_W'(crd_p) - DIFF_W'(crd_a);
         bp_in = DIFF_W'(crd_p) - DIFF_W'(crd_b);
      end else begin
         ab_in = '0;
         ap_in = '0;
         bp_in = '0;
      end
   end

   // lane products
   always_comb begin
      prod_in.ab_ab = ab_ff * ab_ff;
      prod_in.ap_ap = ap_ff * ap_ff;
      prod_in.bp_bp = bp_ff * bp_ff;
      prod_in.ab_ap = ab_ff * ap_ff;
      prod_in.ab_bp = ab_ff * bp_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ab_ff   <= ab_in;
         ap_ff   <= ap_in;
         bp_ff   <= bp_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/core/psd_merge.sv]
// ----------------------------------------------------------------------------
// psd_merge
// Sums the lane products, picks the case and squares the dot product
// ahead of the divider.
// ----------------------------------------------------------------------------
module psd_merge (
   input  logic                  clock,
   input  logic                  adv,
   input  logic                  action,
   input  psd_pkg::psd_prod_type prods [psd_pkg::DIMENSIONS],
   output psd_pkg::psd_div_type  div_out
);
   import psd_pkg::*;

   // stage 1: lane sums
   logic signed [SUM_W-1:0] ab2_in, ap2_in, bp2_in, dot1_in, dotb_in;
   logic signed [SUM_W-1:0] ab2_ff, ap2_ff, bp2_ff, dot1_ff, dotb_ff;
   logic                    act_ff;

   always_comb begin
      ab2_in  = '0;
      ap2_in  = '0;
      bp2_in  = '0;
      dot1_in = '0;
      dotb_in = '0;
      for (int i = 0; i < DIMENSIONS; i++) begin
         ab2_in  = ab2_in  + SUM_W'(prods[i].ab_ab);
         ap2_in  = ap2_in  + SUM_W'(prods[i].ap_ap);
         bp2_in  = bp2_in  + SUM_W'(prods[i].bp_bp);
         dot1_in = dot1_in + SUM_W'(prods[i].ab_ap);
         dotb_in = dotb_in + SUM_W'(prods[i].ab_bp);
      end
   end

   // stage 2: case decision and dot magnitude
   psd_ctrl_type    ctrl2_in, ctrl2_ff;
   logic [SQ_W-1:0] mag_in, mag_ff;
   logic [SQ_W-1:0] ab2_2_ff, ap2_2_ff, bp2_2_ff;
   logic            dot1_pos, dot2_pos;
   logic [SUM_W-1:0] dot1_neg;

   always_comb begin
      dot1_pos = !dot1_ff[SUM_W-1] && (dot1_ff != '0);
      // BA.BP is the negated AB.BP
      dot2_pos = dotb_ff[SUM_W-1];
      ctrl2_in.degenerate = (ab2_ff == '0);
      ctrl2_in.seg_end    = act_ff && !(dot1_pos && dot2_pos);
      dot1_neg = -dot1_ff;
      mag_in   = dot1_ff[SUM_W-1] ? dot1_neg[SQ_W-1:0] : dot1_ff[SQ_W-1:0];
   end

   // stage 3: limb products of the dot magnitude
   logic [2*HALF_W-1:0] hh_ff, hl_ff, ll_ff;
   logic [HALF_W-1:0]   mag_hi, mag_lo;
   psd_ctrl_type        ctrl3_ff;
   logic [SQ_W-1:0]     ab2_3_ff, ap2_3_ff, bp2_3_ff;

   assign mag_hi = mag_ff[SQ_W-1:HALF_W];
   assign mag_lo = mag_ff[HALF_W-1:0];

   // stage 4: dot squared, loaded into the divider word
   logic [NUM_W-1:0] sq_in;
   psd_div_type      div_in, div_ff;

   always_comb begin
      sq_in = (NUM_W'(hh_ff) << (2 * HALF_W)) + (NUM_W'(hl_ff) << (HALF_W + 1))
            + NUM_W'(ll_ff);
      div_in.rem  = sq_in[NUM_W-1:SQ_W];
      div_in.quo  = sq_in[SQ_W-1:0];
      div_in.dvs  = ab2_3_ff;
      div_in.ap2  = ap2_3_ff;
      div_in.bp2  = bp2_3_ff;
      div_in.ctrl = ctrl3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ab2_ff   <= ab2_in;
         ap2_ff   <= ap2_in;
         bp2_ff   <= bp2_in;
         dot1_ff  <= dot1_in;
         dotb_ff  <= dotb_in;
         act_ff   <= action;
         ctrl2_ff <= ctrl2_in;
         mag_ff   <= mag_in;
         ab2_2_ff <= ab2_ff[SQ_W-1:0];
         ap2_2_ff <= ap2_ff[SQ_W-1:0];
         bp2_2_ff <= bp2_ff[SQ_W-1:0];
         hh_ff    <= mag_hi * mag_hi;
         hl_ff    <= mag_hi * mag_lo;
         ll_ff    <= mag_lo * mag_lo;
         ctrl3_ff <= ctrl2_ff;
         ab2_3_ff <= ab2_2_ff;
         ap2_3_ff <= ap2_2_ff;
         bp2_3_ff <= bp2_2_ff;
         div_ff   <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

[rtl/core/psd_div_step.sv]
// ----------------------------------------------------------------------------
// psd_div_step
// One restoring division step: one quotient bit of dot^2 / |AB|^2.
// ----------------------------------------------------------------------------
module psd_div_step (
   input  logic                 clock,
   input  logic                 adv,
   input  psd_pkg::psd_div_type div_in,
   output psd_pkg::psd_div_type div_out
);
   import psd_pkg::*;

   psd_div_type     step_in, step_ff;
   logic [SQ_W:0]   trial, diff;
   logic            ge;

   always_comb begin
      trial   = {div_in.rem, div_in.quo[SQ_W-1]};
      diff    = trial - {1'b0, div_in.dvs};
      ge      = (trial >= {1'b0, div_in.dvs});
      step_in = div_in;
      step_in.rem = ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
      step_in.quo = {div_in.quo[SQ_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         step_ff <= step_in;
      end
   end

   assign div_out = step_ff;

endmodule

[rtl/core/psd_sqrt_step.sv]
// ----------------------------------------------------------------------------
// psd_sqrt_step
// One digit-by-digit integer square root step: one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt_step (
   input  logic                  clock,
   input  logic                  adv,
   input  psd_pkg::psd_sqrt_type sq_in,
   output psd_pkg::psd_sqrt_type sq_out
);
   import psd_pkg::*;

   psd_sqrt_type     step_in, step_ff;
   logic [SQR_W+1:0] cur, trial, diff;
   logic             ge;

   always_comb begin
      cur   = {sq_in.rem, sq_in.rad[SQ_W-1:SQ_W-2]};
      trial = (SQR_W+2)'({sq_in.root, 2'b01});
      diff  = cur - trial;
      ge    = (cur >= trial);
      step_in.rad  = {sq_in.rad[SQ_W-3:0], 2'b00};
      step_in.rem  = ge ? diff[SQR_W-1:0] : cur[SQR_W-1:0];
      step_in.root = {sq_in.root[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         step_ff <= step_in;
      end
   end

   assign sq_out = step_ff;

endmodule

[rtl/core/point_segment_distance_core.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Distance from a query point to the line or segment through two points,
// exact integer arithmetic, result rounded down to Q19.16.
// ----------------------------------------------------------------------------
// request word to response word: lane, merge, divider, root and output registers
// throughput: one word per cycle unless the response is stalled; the 68-step
//    divider and the 34-step root pipelines each take a new word every cycle
// a stalled response holds the whole pipeline
// reset: synchronous, clears all valid bits and sets dims_in_use to 3
module point_segment_distance_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   input  logic signed [31:0] req_query_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [34:0] rsp_distance,
   output logic [1:0]  rsp_nearest_case,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import psd_pkg::*;

   logic                    adv;
   logic [1:0]              dims_ff;
   logic [LATENCY-1:0]      vld_ff;
   logic signed [CRD_W-1:0] crd_a [3];
   logic signed [CRD_W-1:0] crd_b [3];
   logic signed [CRD_W-1:0] crd_p [3];
   psd_prod_type            prods [DIMENSIONS];
   logic                    act1_ff, act2_ff;

   // whole pipeline moves unless the response word is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LATENCY-1];

   // dims register
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
      end else if (csr_wr_en) begin
         dims_ff <= csr_wr_data;
      end
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   assign crd_a = '{req_start_x, req_start_y, req_start_z};
   assign crd_b = '{req_end_x, req_end_y, req_end_z};
   assign crd_p = '{req_query_x, req_query_y, req_query_z};

   // coordinate lanes
   for (genvar i = 0; i < DIMENSIONS; i++) begin : g_lane
      psd_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .active (2'(i) < dims_ff),
         .crd_a  (crd_a[i]),
         .crd_b  (crd_b[i]),
         .crd_p  (crd_p[i]),
         .prod   (prods[i])
      );
   end

   // action follows the lane stages
   always_ff @(posedge clock) begin
      if (adv) begin
         act1_ff <= req_action;
         act2_ff <= act1_ff;
      end
   end

   psd_div_type div_pipe [DIV_STEPS+1];

   psd_merge u_merge (
      .clock   (clock),
      .adv     (adv),
      .action  (act2_ff),
      .prods   (prods),
      .div_out (div_pipe[0])
   );

   // divider chain
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      psd_div_step u_div (
         .clock   (clock),
         .adv     (adv),
         .div_in  (div_pipe[k]),
         .div_out (div_pipe[k+1])
      );
   end

   // line radicand: |AP|^2 - ceil(dot^2 / |AB|^2)
   psd_div_type     div_last;
   logic [SQ_W:0]   ceil_q, ap2_ext, line_diff;
   logic [SQ_W-1:0] line_rad;
   psd_sqrt_type    rad_a_in, rad_b_in;
   psd_sqrt_type    sqa [SQRT_STEPS+1];
   psd_sqrt_type    sqb [SQRT_STEPS+1];
   psd_ctrl_type    ctrl_fx_ff;
   psd_ctrl_type    ctl_dly_ff [SQRT_STEPS];

   always_comb begin
      div_last  = div_pipe[DIV_STEPS];
      ceil_q    = {1'b0, div_last.quo} + (SQ_W+1)'(div_last.rem != '0);
      ap2_ext   = {1'b0, div_last.ap2};
      line_diff = ap2_ext - ceil_q;
      line_rad  = (ap2_ext >= ceil_q) ? line_diff[SQ_W-1:0] : '0;
      rad_a_in.rad  = (div_last.ctrl.degenerate || div_last.ctrl.seg_end)
                    ? div_last.ap2 : line_rad;
      rad_a_in.rem  = '0;
      rad_a_in.root = '0;
      rad_b_in.rad  = div_last.bp2;
      rad_b_in.rem  = '0;
      rad_b_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqa[0]        <= rad_a_in;
         sqb[0]        <= rad_b_in;
         ctrl_fx_ff    <= div_last.ctrl;
         ctl_dly_ff[0] <= ctrl_fx_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            ctl_dly_ff[k] <= ctl_dly_ff[k-1];
         end
      end
   end

   // root chains for the selected radicand and for |BP|^2
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      psd_sqrt_step u_sqa (
         .clock  (clock),
         .adv    (adv),
         .sq_in  (sqa[k]),
         .sq_out (sqa[k+1])
      );
      psd_sqrt_step u_sqb (
         .clock  (clock),
         .adv    (adv),
         .sq_in  (sqb[k]),
         .sq_out (sqb[k+1])
      );
   end

   // result selection
   psd_ctrl_type      ctrl_out;
   logic [ROOT_W-1:0] root_a, root_b;
   logic [DIST_W-1:0] dist_in, dist_ff;
   logic [1:0]        kind_in, kind_ff;

   always_comb begin
      ctrl_out = ctl_dly_ff[SQRT_STEPS-1];
      root_a   = sqa[SQRT_STEPS].root;
      root_b   = sqb[SQRT_STEPS].root;
      if (ctrl_out.degenerate) begin
         dist_in = DIST_W'(root_a);
         kind_in = CASE_DEGEN;
      end else if (ctrl_out.seg_end) begin
         if (root_a <= root_b) begin
            dist_in = DIST_W'(root_a);
            kind_in = CASE_START;
         end else begin
            dist_in = DIST_W'(root_b);
            kind_in = CASE_END;
         end
      end else begin
         dist_in = DIST_W'(root_a);
         kind_in = CASE_PERP;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_distance     = dist_ff;
   assign rsp_nearest_case = kind_ff;

endmodule

[sim/psd_checker.sv]
// ----------------------------------------------------------------------------
// psd_checker
// Watches the request, response and csr ports of the distance core, computes
// the expected distance and nearest case for every accepted request word with
// exact wide integers, and compares response words in order.
// ----------------------------------------------------------------------------
module psd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_start_z,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   input  logic [31:0] req_end_z,
   input  logic [31:0] req_query_x,
   input  logic [31:0] req_query_y,
   input  logic [31:0] req_query_z,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [34:0] rsp_distance,
   input  logic [1:0]  rsp_nearest_case,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import psd_pkg::*;

   typedef logic [159:0]       wide_type;
   typedef logic signed [79:0] acc_type;

   typedef struct packed {
      logic [34:0] distance;
      logic [1:0]  nearest_case;
   } dist_word_type;

   dist_word_type expected_words[$];
   logic [1:0]    dims_shadow;

   assign pending = expected_words.size();

   // largest r below 2^35 with r*r*den <= num
   function automatic logic [34:0] floor_root(wide_type num, wide_type den);
      logic [34:0] r;
      logic [34:0] c;
      wide_type    t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = r | (35'd1 << b);
         t = wide_type'(c) * wide_type'(c) * den;
         if (t <= num) r = c;
      end
      return r;
   endfunction

   function automatic dist_word_type predict_distance(
      logic act, logic [1:0] dims,
      logic [2:0][31:0] a, logic [2:0][31:0] b, logic [2:0][31:0] p);
      int            lanes;
      acc_type       ab, ap, ba, bp;
      acc_type       ab2, ap2, bp2, dot_a, dot_b, dot_mag;
      wide_type      prod, dd, num;
      logic [34:0]   da, db;
      dist_word_type w;
      lanes = (dims < DIMENSIONS) ? dims : DIMENSIONS;
      ab2 = '0; ap2 = '0; bp2 = '0; dot_a = '0; dot_b = '0;
      for (int i = 0; i < lanes; i++) begin
         ab = $signed(b[i]) - $signed(a[i]);
         ap = $signed(p[i]) - $signed(a[i]);
         ba = $signed(a[i]) - $signed(b[i]);
         bp = $signed(p[i]) - $signed(b[i]);
         ab2   += ab * ab;
         ap2   += ap * ap;
         bp2   += bp * bp;
         dot_a += ab * ap;
         dot_b += ba * bp;
      end
      if (ab2 == 0) begin
         w.distance     = floor_root(wide_type'($unsigned(ap2)), wide_type'(1));
         w.nearest_case = CASE_DEGEN;
      end else if (act && !(dot_a > 0 && dot_b > 0)) begin
         // beyond an end of the segment: nearer endpoint, ties go to start
         da = floor_root(wide_type'($unsigned(ap2)), wide_type'(1));
         db = floor_root(wide_type'($unsigned(bp2)), wide_type'(1));
         if (da <= db) begin
            w.distance = da; w.nearest_case = CASE_START;
         end else begin
            w.distance = db; w.nearest_case = CASE_END;
         end
      end else begin
         dot_mag = (dot_a < 0) ? -dot_a : dot_a;
         prod = wide_type'($unsigned(ap2)) * wide_type'($unsigned(ab2));
         dd   = wide_type'($unsigned(dot_mag)) * wide_type'($unsigned(dot_mag));
         num  = (prod >= dd) ? prod - dd : '0;
         w.distance     = floor_root(num, wide_type'($unsigned(ab2)));
         w.nearest_case = CASE_PERP;
      end
      return w;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // track config, queue predictions, compare response words
   always @(posedge clock) begin
      dist_word_type want;
      if (reset) begin
         dims_shadow = DIMS_RESET;
         fail_count  = 0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) dims_shadow = csr_wr_data;
         if (req_valid && !req_stall)
            expected_words.push_back(predict_distance(req_action, dims_shadow,
               {req_start_z, req_start_y, req_start_x},
               {req_end_z, req_end_y, req_end_x},
               {req_query_z, req_query_y, req_query_x}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch($sformatf("distance got %0d want %0d",
                     rsp_distance, want.distance));
               if (rsp_nearest_case !== want.nearest_case)
                  report_mismatch($sformatf("nearest_case got %0d want %0d",
                     rsp_nearest_case, want.nearest_case));
            end
         end
      end
   end
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the point to line / segment distance core: directed corner
// words, then random queries over every dims setting and idle pattern, with
// a long response hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psd_pkg::*;

   localparam logic [31:0] MAX_CRD = 32'h7fff_ffff;
   localparam logic [31:0] MIN_CRD = 32'h8000_0000;
   localparam logic        ACT_LINE = 1'b0;
   localparam logic        ACT_SEG  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic signed [31:0] sa [3] = '{default: '0};
   logic signed [31:0] sb [3] = '{default: '0};
   logic signed [31:0] sp [3] = '{default: '0};
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [34:0] rsp_distance;
   logic [1:0]  rsp_nearest_case;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0;
   logic        hold_off = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          fail_count;
   int          pending;

   always #2 clock = ~clock;

   point_segment_distance_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_action,
      .req_start_x(sa[0]), .req_start_y(sa[1]), .req_start_z(sa[2]),
      .req_end_x(sb[0]), .req_end_y(sb[1]), .req_end_z(sb[2]),
      .req_query_x(sp[0]), .req_query_y(sp[1]), .req_query_z(sp[2]),
      .rsp_valid, .rsp_stall, .rsp_distance, .rsp_nearest_case,
      .csr_wr_en, .csr_wr_data
   );

   psd_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_action,
      .req_start_x(sa[0]), .req_start_y(sa[1]), .req_start_z(sa[2]),
      .req_end_x(sb[0]), .req_end_y(sb[1]), .req_end_z(sb[2]),
      .req_query_x(sp[0]), .req_query_y(sp[1]), .req_query_z(sp[2]),
      .rsp_valid, .rsp_stall, .rsp_distance, .rsp_nearest_case,
      .csr_wr_en, .csr_wr_data, .fail_count, .pending
   );

   // response side stall
   always @(posedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < rsp_stall_pct);

   // offer one request word, with random idle cycles first
   task automatic send_word(input logic act,
      input logic [31:0] ax, ay, az, bx, by, bz, px, py, pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_action <= act;
      sa[0] <= ax; sa[1] <= ay; sa[2] <= az;
      sb[0] <= bx; sb[1] <= by; sb[2] <= bz;
      sp[0] <= px; sp[1] <= py; sp[2] <= pz;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drain, let the pipeline empty, then write dims_in_use
   task automatic set_dims(input logic [1:0] dims);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dims;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_crd(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(4000)) - 2000) <<< 8;
         default: case ($urandom_range(3))
            0: return MAX_CRD;
            1: return MIN_CRD;
            2: return '0;
            default: return $urandom;
         endcase
      endcase
   endfunction

   task automatic send_random();
      logic [31:0] a [3];
      logic [31:0] b [3];
      logic [31:0] p [3];
      int shape;
      int mode;
      shape = $urandom_range(9);
      mode  = (shape < 4) ? 0 : (shape < 8) ? 1 : 2;
      for (int i = 0; i < 3; i++) begin
         a[i] = rand_crd(mode);
         b[i] = rand_crd(mode);
         p[i] = rand_crd(mode);
      end
      // degenerate line
      if (shape == 5) b = a;
      // point at the midpoint of the end points' coordinates gives ties
      if (shape == 6)
         for (int i = 0; i < 3; i++) begin
            b[i] = a[i] + 32'($signed($urandom_range(512)) - 256) * 2;
            p[i] = a[i] + ((b[i] - a[i]) >>> 1);
         end
      send_word($urandom_range(1), a[0], a[1], a[2], b[0], b[1], b[2],
         p[0], p[1], p[2]);
   endtask

   // run limit
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [1:0] dims_seq [8];
      dims_seq = '{3, 1, 2, 0, 3, 2, 1, 3};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset dims
      send_word(ACT_LINE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(ACT_SEG, 0, 0, 0, 0, 0, 0, MAX_CRD, MAX_CRD, MAX_CRD);
      send_word(ACT_LINE, MIN_CRD, MIN_CRD, MIN_CRD, MAX_CRD, MAX_CRD, MAX_CRD,
         MIN_CRD, MAX_CRD, MIN_CRD);
      send_word(ACT_SEG, MIN_CRD, MIN_CRD, MIN_CRD, MAX_CRD, MAX_CRD, MAX_CRD,
         MIN_CRD, MAX_CRD, MIN_CRD);
      send_word(ACT_SEG, MAX_CRD, MAX_CRD, MAX_CRD, MIN_CRD, MIN_CRD, MIN_CRD,
         MIN_CRD, MIN_CRD, MIN_CRD);
      send_word(ACT_SEG, MIN_CRD, MIN_CRD, MIN_CRD, MIN_CRD, MIN_CRD, MIN_CRD,
         MAX_CRD, MAX_CRD, MAX_CRD);
      send_word(ACT_LINE, 5, 5, 5, 5, 5, 5, 9, 1, 3);
      // perpendicular foot inside the segment
      send_word(ACT_SEG, 0, 0, 0, 32'h40000, 0, 0, 32'h10000, 32'h30000, 0);
      // beyond the start and beyond the end
      send_word(ACT_SEG, 0, 0, 0, 32'h40000, 0, 0, -32'sh20000, 32'h10000, 0);
      send_word(ACT_SEG, 0, 0, 0, 32'h40000, 0, 0, 32'h70000, 32'h10000, 0);
      send_word(ACT_LINE, 0, 0, 0, 32'h40000, 0, 0, 32'h70000, 32'h10000, 0);
      // equidistant end points
      send_word(ACT_SEG, 0, 0, 0, 32'h20000, 0, 0, 32'h10000, 0, 0);
      send_word(ACT_SEG, 0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h50000, 0);
      send_word(ACT_SEG, 0, 0, 0, 2, 0, 0, 1, 0, 7);
      // point on an end point
      send_word(ACT_SEG, 1, 2, 3, 4, 5, 6, 4, 5, 6);
      send_word(ACT_SEG, 1, 2, 3, 4, 5, 6, 1, 2, 3);
      send_word(ACT_LINE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         1, 1, 1, 32'hffffffff, 1, 32'hffffffff);

      for (int ph = 0; ph < 8; ph++) begin
         set_dims(dims_seq[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         // long response hold-off so the pipeline fills and stalls requests
         if (ph == 0)
            fork begin
               hold_off <= 1'b1;
               repeat (400) @(posedge clock);
               hold_off <= 1'b0;
            end join_none
         for (int n = 0; n < 240; n++) begin
            // a quiet run of cycles within each phase
            if (n == 120) begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            send_random();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
